[src/lft_pkg.sv]
// Package for the link frame transmitter: codes, job descriptor, constants.
`default_nettype none
package lft_pkg;

  localparam logic [7:0]  FLAG_BYTE   = 8'h0F;
  localparam logic [7:0]  ESC_BYTE    = 8'hF0;
  localparam logic [31:0] CRC_POLY    = 32'h04C11DB7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 3;

  // Register addresses (byte addresses, decoded on bit 2)
  localparam logic ADDR_FRAMING = 1'b0;
  localparam logic ADDR_CHECK   = 1'b1;

  // Check appended after a job's bytes
  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_EVEN,
    CHK_ODD,
    CHK_CRC
  } chk_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTES,
    ST_CHECK
  } bk_state_e;

  typedef struct packed {
    logic       framing_mode;
    logic [1:0] check_mode;
  } cfg_t;

  // One item's worth of line work: up to four bytes, left aligned
  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  nbytes_m1;
    chk_e        chk;
  } job_t;

endpackage
`default_nettype wire

[src/lft_if.sv]
// Handshake interfaces for input items and line bit results.
`default_nettype none
interface lft_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] frame_length;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output frame_length,
                  output end_of_frame, input ready);
  modport sink (input valid, input data_byte, input frame_length,
                input end_of_frame, output ready);
endinterface

interface lft_bit_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic frame_done;

  modport source (output valid, output line_bit, output frame_done, input ready);
  modport sink (input valid, input line_bit, input frame_done, output ready);
endinterface
`default_nettype wire

[src/lft_front.sv]
// Front end: accepts items, tracks frame start, builds the byte job.
`default_nettype none
module lft_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lft_item_if.sink         item_i,
  input  wire lft_pkg::cfg_t cfg_i,
  input  wire logic        q_full_i,
  output      logic        push_o,
  output      lft_pkg::job_t job_o
);
  import lft_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic       accept;
  logic       hdr_en, esc_en, trl_en;
  logic [7:0] hdr_byte;
  logic [31:0] acc;
  logic [2:0] n;
  logic [1:0] nb_m1;

  assign item_i.ready = !q_full_i;
  assign accept       = item_i.valid && !q_full_i;
  assign push_o       = accept;

  assign hdr_en   = !in_frame_q;
  assign hdr_byte = cfg_i.framing_mode ? FLAG_BYTE : item_i.frame_length;
  assign esc_en   = cfg_i.framing_mode &&
                    (item_i.data_byte == FLAG_BYTE || item_i.data_byte == ESC_BYTE);
  assign trl_en   = cfg_i.framing_mode && item_i.end_of_frame;

  // Pack header, escape, data and trailer in line order
  always_comb begin
    acc = '0;
    n   = '0;
    if (hdr_en) begin
      acc = {acc[23:0], hdr_byte};
      n   = n + 3'd1;
    end
    if (esc_en) begin
      acc = {acc[23:0], ESC_BYTE};
      n   = n + 3'd1;
    end
    acc = {acc[23:0], item_i.data_byte};
    n   = n + 3'd1;
    if (trl_en) begin
      acc = {acc[23:0], FLAG_BYTE};
      n   = n + 3'd1;
    end
  end

  assign nb_m1 = 2'(n - 3'd1);

  always_comb begin
    job_o.bytes     = acc << {~nb_m1, 3'b000};
    job_o.nbytes_m1 = nb_m1;
    if (!item_i.end_of_frame) begin
      job_o.chk = CHK_NONE;
    end else if (cfg_i.check_mode[1]) begin
      job_o.chk = CHK_CRC;
    end else if (cfg_i.check_mode[0]) begin
      job_o.chk = CHK_ODD;
    end else begin
      job_o.chk = CHK_EVEN;
    end
  end

  assign in_frame_d = accept ? !item_i.end_of_frame : in_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule
`default_nettype wire

[src/lft_queue.sv]
// Short job queue between front end and serializer.
`default_nettype none
module lft_queue #(
  parameter int unsigned Depth = lft_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lft_pkg::job_t wdata_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      logic          valid_o,
  output      lft_pkg::job_t rdata_o
);
  import lft_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[src/lft_back.sv]
// Serializer: shifts job bytes out MSB first, keeps CRC/parity, appends check.
`default_nettype none
module lft_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire lft_pkg::job_t job_i,
  output      logic          pop_o,
  lft_bit_if.source          bit_o
);
  import lft_pkg::*;

  bk_state_e   state_q, state_d;
  logic [31:0] shreg_q, shreg_d;
  logic [4:0]  cnt_q, cnt_d;
  chk_e        chk_q, chk_d;
  logic [31:0] crc_q, crc_d, crc_step;
  logic        par_q, par_d, par_step;
  logic        ovalid_q, ovalid_d, obit_q, odone_q;

  logic cur_bit, advance, bytes_end, check_end, job_end, load, enter_check;

  assign cur_bit  = shreg_q[31];
  assign crc_step = {crc_q[30:0], 1'b0} ^ ((crc_q[31] ^ cur_bit) ? CRC_POLY : 32'h0);
  assign par_step = par_q ^ cur_bit;

  // Control outputs
  always_comb begin
    advance     = (state_q != ST_IDLE) && (!ovalid_q || bit_o.ready);
    bytes_end   = (state_q == ST_BYTES) && (cnt_q == '0);
    check_end   = (state_q == ST_CHECK) && (cnt_q == '0);
    job_end     = advance && ((bytes_end && chk_q == CHK_NONE) || check_end);
    enter_check = advance && bytes_end && (chk_q != CHK_NONE);
    load        = q_valid_i && ((state_q == ST_IDLE) || job_end);
  end

  assign pop_o = load;

  // Next state
  always_comb begin
    state_d = state_q;
    if (load) begin
      state_d = ST_BYTES;
    end else if (enter_check) begin
      state_d = ST_CHECK;
    end else if (job_end) begin
      state_d = ST_IDLE;
    end
  end

  // Datapath
  always_comb begin
    shreg_d = shreg_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    if (load) begin
      shreg_d = job_i.bytes;
      cnt_d   = {job_i.nbytes_m1, 3'b111};
      chk_d   = job_i.chk;
    end else if (enter_check) begin
      if (chk_q == CHK_CRC) begin
        shreg_d = crc_step;
        cnt_d   = 5'd31;
      end else begin
        shreg_d = {par_step ^ (chk_q == CHK_ODD), 31'b0};
        cnt_d   = 5'd0;
      end
    end else if (advance) begin
      shreg_d = {shreg_q[30:0], 1'b0};
      cnt_d   = cnt_q - 5'd1;
    end

    crc_d = crc_q;
    par_d = par_q;
    if (advance && state_q == ST_BYTES) begin
      crc_d = crc_step;
      par_d = par_step;
    end else if (advance && check_end) begin
      crc_d = '0;
      par_d = 1'b0;
    end

    if (advance) begin
      ovalid_d = 1'b1;
    end else if (bit_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chk_q    <= CHK_NONE;
      cnt_q    <= '0;
      crc_q    <= '0;
      par_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      chk_q    <= chk_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      par_q    <= par_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    if (advance) begin
      obit_q  <= cur_bit;
      odone_q <= check_end;
    end
  end

  assign bit_o.valid      = ovalid_q;
  assign bit_o.line_bit   = obit_q;
  assign bit_o.frame_done = odone_q;

endmodule
`default_nettype wire

[src/link_frame_transmitter_unit.sv]
// Top level of the link frame transmitter: config registers, front end, queue, serializer.
//
// Usage:
//  - item_i carries payload bytes of a frame (data_byte, frame_length, end_of_frame);
//    frame_length is sampled only on the first byte of a frame.
//  - bit_o delivers framed line bits MSB first, one per handshake; frame_done marks the
//    final check bit of a frame.
//  - APB port: 0x0 framing_mode (0 length header, 1 flag + escape stuffing),
//    0x4 check_mode (0 even parity, 1 odd parity, 2/3 CRC-32). Write only while idle.
// Timing:
//  - An item's first bit passes the job queue, shift register and output register.
//  - The serializer emits one bit per cycle while bit_o.ready is high and jobs wait,
//    so an item is 8 to 64 bits (8 per line byte, plus 1 or 32 check bits on the
//    last byte); the shift register of the serializer sets that rate.
//  - The front end keeps accepting until the job queue (Depth entries) fills,
//    so the next item is taken while the current one is still shifting out.
// Reset: queue empty, no frame open, CRC and parity cleared, registers zero.
// Stall: a low bit_o.ready holds the output register; the serializer freezes
//  and, once the queue is full, item_i.ready drops.
`default_nettype none
module link_frame_transmitter_unit #(
  parameter int unsigned QueueDepth = lft_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  lft_item_if.sink                        item_i,
  lft_bit_if.source                       bit_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lft_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);
  import lft_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  wr_en;
  logic  push, q_full, q_valid, pop;
  job_t  job_in, job_out;

  // APB registers, decoded on address bit 2
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        ADDR_FRAMING: cfg_d.framing_mode = pwdata[0];
        ADDR_CHECK:   cfg_d.check_mode   = pwdata[1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_FRAMING: prdata = {31'b0, cfg_q.framing_mode};
      ADDR_CHECK:   prdata = {30'b0, cfg_q.check_mode};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lft_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job_in)
  );

  lft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (job_out)
  );

  lft_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (job_out),
    .pop_o     (pop),
    .bit_o     (bit_o)
  );

endmodule
`default_nettype wire

[tb/sv/link_frame_transmitter_unit_test.sv]
// Self-checking testbench for link_frame_transmitter_unit: directed table, then random frames.
module link_frame_transmitter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lft_pkg::*;

  // Check code as written to the check_mode register; code 3 acts as CRC-32
  typedef enum logic [1:0] {
    CHECK_EVEN    = 2'd0,
    CHECK_ODD     = 2'd1,
    CHECK_CRC     = 2'd2,
    CHECK_CRC_ALT = 2'd3
  } check_mode_e;

  typedef enum logic {
    FRAME_COUNT = 1'b0,  // length byte header
    FRAME_FLAGS = 1'b1   // flag delimiters, escape stuffing
  } framing_e;

  typedef struct packed {
    logic line_bit;
    logic frame_done;
  } line_bit_t;

  // One row of the directed table. typed_n != 0 means the line bits are
  // written out in typed_bits (MSB first, lowest typed_n bits used).
  typedef struct packed {
    logic        wr_cfg;
    framing_e    framing;
    check_mode_e check;
    logic [7:0]  data;
    logic [7:0]  len;
    logic        eof;
    logic [6:0]  typed_n;
    logic [63:0] typed_bits;
  } row_t;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lft_item_if item_if();
  lft_bit_if  bit_if();

  link_frame_transmitter_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .bit_o   (bit_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Line bits still owed by the block, oldest first
  line_bit_t line_bits_due[$];
  // Scratch: line bits the framer model produced for the item just taken
  line_bit_t framed_bits[$];
  row_t plan[$];

  // Framer model state and its copy of the registers
  framing_e    cfg_framing;
  check_mode_e cfg_check;
  logic        frame_open;
  logic [31:0] crc_acc;
  logic        ones_acc;

  int unsigned failures;
  int unsigned bits_seen;
  int unsigned cycle_count;
  bit          steady_source;  // no gaps between items while set
  bit          steady_sink;    // no stalls on the bit side while set

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Framer model: every emitted bit feeds the CRC-32 (MSB first, zero init)
  // and the running ones parity, headers, flags and escapes included.
  // ---------------------------------------------------------------------------
  function automatic void emit_bit(input logic b);
    logic fb;
    framed_bits.insert(framed_bits.size(), line_bit_t'{line_bit: b, frame_done: 1'b0});
    fb = crc_acc[31] ^ b;
    crc_acc = {crc_acc[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    ones_acc ^= b;
  endfunction

  function automatic void emit_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) emit_bit(v[i]);
  endfunction

  function automatic void frame_line_bits(input logic [7:0] data, input logic [7:0] len,
                                          input logic eof);
    logic [31:0] crc_snap;
    // Frame start: header follows framing_mode as it is now
    if (!frame_open) begin
      crc_acc  = '0;
      ones_acc = 1'b0;
      if (cfg_framing == FRAME_FLAGS) emit_byte(FLAG_BYTE);
      else emit_byte(len);  // sent as given, never checked against the byte count
      frame_open = 1'b1;
    end
    if (cfg_framing == FRAME_FLAGS && (data == FLAG_BYTE || data == ESC_BYTE))
      emit_byte(ESC_BYTE);
    emit_byte(data);
    if (eof) begin
      if (cfg_framing == FRAME_FLAGS) emit_byte(FLAG_BYTE);
      // High bit of the check code picks CRC, so the unused code is CRC too
      if (cfg_check[1]) begin
        crc_snap = crc_acc;
        for (int i = 31; i >= 0; i--) emit_bit(crc_snap[i]);
      end else if (cfg_check == CHECK_ODD) begin
        emit_bit(~ones_acc);
      end else begin
        emit_bit(ones_acc);
      end
      framed_bits[framed_bits.size() - 1].frame_done = 1'b1;
      frame_open = 1'b0;
      crc_acc    = '0;
      ones_acc   = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item source. Called at a rising edge; returns at the edge that took the item.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] data, input logic [7:0] len, input logic eof,
                           input int typed_n, input logic [63:0] typed_bits);
    int gap;
    gap = steady_source ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.data_byte    <= data;
    item_if.frame_length <= len;
    item_if.end_of_frame <= eof;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    // Taken: run the model even for typed rows so its state stays in step
    framed_bits.delete();
    frame_line_bits(data, len, eof);
    if (typed_n != 0) begin
      for (int k = typed_n - 1; k >= 0; k--)
        line_bits_due.insert(line_bits_due.size(),
                             line_bit_t'{line_bit: typed_bits[k], frame_done: eof && k == 0});
    end else begin
      foreach (framed_bits[k]) line_bits_due.insert(line_bits_due.size(), framed_bits[k]);
    end
  endtask

  // Stop offering items and wait until every owed bit has come out
  task automatic drain_items();
    item_if.valid <= 1'b0;
    while (line_bits_due.size() != 0) @(posedge clk);
  endtask

  // APB write (setup + access), then a read back of the same register
  task automatic program_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value)
      note_failure($sformatf("register at 0x%0h: want %0h, read %0h", addr, value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Registers change only with nothing owed; a frame may still be open
  task automatic apply_cfg(input framing_e fr, input check_mode_e ck);
    drain_items();
    program_reg({ADDR_FRAMING, 2'b00}, 32'(fr));
    program_reg({ADDR_CHECK, 2'b00}, 32'(ck));
    cfg_framing = fr;
    cfg_check   = ck;
  endtask

  function automatic row_t row(input logic wr, input framing_e fr, input check_mode_e ck,
                               input logic [7:0] d, input logic [7:0] l, input logic e,
                               input int n, input logic [63:0] b);
    row_t r;
    r.wr_cfg     = wr;
    r.framing    = fr;
    r.check      = ck;
    r.data       = d;
    r.len        = l;
    r.eof        = e;
    r.typed_n    = 7'(n);
    r.typed_bits = b;
    return r;
  endfunction

  function automatic void add_row(input row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Bit sink: random stall before each bit, with stall-free stretches
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int taken;
    taken = 0;
    bit_if.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = steady_sink ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        bit_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      bit_if.ready <= 1'b1;
      @(posedge clk);
      while (!bit_if.valid) @(posedge clk);
      taken++;
      if (taken % 64 == 0) steady_sink = ($urandom_range(0, 2) == 0);
    end
  end

  // Compare each line bit taken with the oldest one owed
  always @(posedge clk) begin
    line_bit_t want;
    if (rst_n && bit_if.valid && bit_if.ready) begin
      if (line_bits_due.size() == 0) begin
        note_failure($sformatf("line bit %0d: none owed, got bit=%b done=%b",
                               bits_seen, bit_if.line_bit, bit_if.frame_done));
      end else begin
        want = line_bits_due.pop_front();
        if (bit_if.line_bit !== want.line_bit || bit_if.frame_done !== want.frame_done)
          note_failure($sformatf("line bit %0d: want bit=%b done=%b, got bit=%b done=%b",
                                 bits_seen, want.line_bit, want.frame_done,
                                 bit_if.line_bit, bit_if.frame_done));
      end
      bits_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n_bytes;
    int sent;
    logic [7:0] d;
    logic [7:0] l;

    failures      = 0;
    bits_seen     = 0;
    cycle_count   = 0;
    steady_source = 1'b0;
    steady_sink   = 1'b0;
    cfg_framing   = FRAME_COUNT;
    cfg_check     = CHECK_EVEN;
    frame_open    = 1'b0;
    crc_acc       = '0;
    ones_acc      = 1'b0;

    rst_n                = 1'b0;
    item_if.valid        = 1'b0;
    item_if.data_byte    = '0;
    item_if.frame_length = '0;
    item_if.end_of_frame = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;

    // Directed table
    //          wr  framing      check          data   len    eof typed
    // after reset: count header, even parity
    add_row(row(0, FRAME_COUNT, CHECK_EVEN,    8'h00, 8'h01, 1, 17,
                {8'h01, 8'h00, 1'b1}));
    add_row(row(0, FRAME_COUNT, CHECK_EVEN,    8'hFF, 8'hFF, 1, 17,
                {8'hFF, 8'hFF, 1'b0}));
    add_row(row(1, FRAME_COUNT, CHECK_ODD,     8'hFF, 8'hFF, 1, 17,
                {8'hFF, 8'hFF, 1'b1}));
    // multi-byte frame with matching length
    add_row(row(0, FRAME_COUNT, CHECK_ODD,     8'h12, 8'h03, 0, 0, '0));
    add_row(row(0, FRAME_COUNT, CHECK_ODD,     8'h34, 8'h03, 0, 0, '0));
    add_row(row(0, FRAME_COUNT, CHECK_ODD,     8'h56, 8'h03, 1, 0, '0));
    // length field that disagrees with the bytes sent
    add_row(row(1, FRAME_COUNT, CHECK_EVEN,    8'hAA, 8'h05, 0, 0, '0));
    add_row(row(0, FRAME_COUNT, CHECK_EVEN,    8'h55, 8'h05, 1, 0, '0));
    // CRC over all-zero frame stays zero
    add_row(row(1, FRAME_COUNT, CHECK_CRC,     8'h00, 8'h00, 1, 48,
                {8'h00, 8'h00, 32'h0}));
    add_row(row(0, FRAME_COUNT, CHECK_CRC,     8'hFF, 8'h80, 1, 0, '0));
    // single stuffed byte with CRC: longest item, 64 bits
    add_row(row(1, FRAME_FLAGS, CHECK_CRC,     8'h0F, 8'hFF, 1, 0, '0));
    add_row(row(0, FRAME_FLAGS, CHECK_CRC,     8'hF0, 8'h00, 1, 0, '0));
    add_row(row(1, FRAME_FLAGS, CHECK_EVEN,    8'h00, 8'hFF, 1, 25,
                {8'h0F, 8'h00, 8'h0F, 1'b0}));
    // unused check code behaves as CRC
    add_row(row(1, FRAME_FLAGS, CHECK_CRC_ALT, 8'h0F, 8'h11, 0, 0, '0));
    add_row(row(0, FRAME_FLAGS, CHECK_CRC_ALT, 8'hF0, 8'h22, 0, 0, '0));
    add_row(row(0, FRAME_FLAGS, CHECK_CRC_ALT, 8'h7E, 8'h33, 1, 0, '0));
    // register changes inside an open frame
    add_row(row(1, FRAME_FLAGS, CHECK_ODD,     8'h3C, 8'h09, 0, 0, '0));
    add_row(row(1, FRAME_COUNT, CHECK_EVEN,    8'h0F, 8'h09, 0, 0, '0));
    add_row(row(1, FRAME_COUNT, CHECK_CRC,     8'hF0, 8'h09, 1, 0, '0));
    add_row(row(1, FRAME_COUNT, CHECK_ODD,     8'h81, 8'h02, 0, 0, '0));
    add_row(row(1, FRAME_FLAGS, CHECK_EVEN,    8'h0F, 8'h02, 1, 0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr_cfg) apply_cfg(plan[i].framing, plan[i].check);
      send_item(plan[i].data, plan[i].len, plan[i].eof, plan[i].typed_n, plan[i].typed_bits);
    end

    // Random frames, one phase per register setting (all eight codes)
    for (int p = 0; p < 8; p++) begin
      apply_cfg(framing_e'(p[0]), check_mode_e'(p[2:1]));
      sent = 0;
      while (sent < 45) begin
        n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        // mostly a true count, sometimes any value
        l = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(n_bytes);
        steady_source = ($urandom_range(0, 3) == 0);
        for (int b = 0; b < n_bytes; b++) begin
          // flag and escape values often, to exercise stuffing
          case ($urandom_range(0, 7))
            0: d = FLAG_BYTE;
            1: d = ESC_BYTE;
            default: d = 8'($urandom_range(0, 255));
          endcase
          send_item(d, l, b == n_bytes - 1, 0, '0);
        end
        sent += n_bytes;
      end
    end

    // Wait out everything owed, then watch for stray bits
    drain_items();
    repeat (20) @(posedge clk);
    if (failures == 0 && line_bits_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
src/lft_pkg.sv
src/lft_if.sv
src/lft_front.sv
src/lft_queue.sv
src/lft_back.sv
src/link_frame_transmitter_unit.sv
tb/sv/link_frame_transmitter_unit_test.sv
